// File: rtl/fabs_pkg.sv
// Shared types and constants for the fix acquisition backoff scheduler.
// No dependencies; used by every module under rtl/.
package fabs_pkg;

  localparam int CFG_W    = 16;
  localparam int MS_BITS  = 26;  // 16-bit seconds times 1000 fits in 26 bits
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 3;
  localparam int RES_W    = 40;  // 38 result bits padded to whole bytes

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE     = 3'd0,
    ST_PENDING  = 3'd1,
    ST_CURRENT  = 3'd2,
    ST_PREVIOUS = 3'd3,
    ST_TIMEOUT  = 3'd4
  } fix_status_t;

  localparam logic       OP_POLL    = 1'b0;
  localparam logic       OP_EVENT   = 1'b1;
  localparam logic [1:0] EV_FIX     = 2'd0;
  localparam logic [1:0] EV_TIMEOUT = 2'd1;

  localparam logic [IDX_W-1:0] REG_INITIAL_TIMEOUT = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_TIMEOUT     = 3'd1;
  localparam logic [IDX_W-1:0] REG_SCAN_TIMEOUT    = 3'd2;
  localparam logic [IDX_W-1:0] REG_STALE_LIMIT     = 3'd3;
  localparam logic [IDX_W-1:0] REG_INITIAL_PROBE   = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_PROBE       = 3'd5;
  localparam logic [IDX_W-1:0] REG_SCAN_PERIOD     = 3'd6;

  localparam logic [CFG_W-1:0] INITIAL_TIMEOUT_RST = 16'd120;
  localparam logic [CFG_W-1:0] MAX_TIMEOUT_RST     = 16'd300;
  localparam logic [CFG_W-1:0] SCAN_TIMEOUT_RST    = 16'd30;
  localparam logic [CFG_W-1:0] STALE_LIMIT_RST     = 16'd300;
  localparam logic [CFG_W-1:0] INITIAL_PROBE_RST   = 16'd240;
  localparam logic [CFG_W-1:0] MAX_PROBE_RST       = 16'd3600;
  localparam logic [CFG_W-1:0] SCAN_PERIOD_RST     = 16'd60;

  localparam logic [MS_BITS-1:0] MS_PER_S = 26'd1000;

  typedef struct packed {
    logic [CFG_W-1:0] initial_timeout_s;
    logic [CFG_W-1:0] max_timeout_s;
    logic [CFG_W-1:0] scan_timeout_s;
    logic [CFG_W-1:0] stale_limit_s;
    logic [CFG_W-1:0] initial_probe_s;
    logic [CFG_W-1:0] max_probe_s;
    logic [CFG_W-1:0] scan_period_s;
  } cfg_t;

  typedef struct packed {
    logic              fix_notify;
    fix_status_t       fix_status;
    logic              request_visibility;
    logic [CFG_W-1:0]  request_timeout_s;
    logic [CFG_W-1:0]  request_period_s;
    logic              request_start;
  } result_t;

  // seconds to milliseconds, constant multiply
  function automatic logic [MS_BITS-1:0] to_ms(input logic [CFG_W-1:0] s);
    logic [MS_BITS-1:0] p;
    p = {{(MS_BITS-CFG_W){1'b0}}, s} * MS_PER_S;
    return p;
  endfunction

  // double a value, capped
  function automatic logic [CFG_W-1:0] double_capped(input logic [CFG_W-1:0] v,
                                                     input logic [CFG_W-1:0] cap);
    logic [CFG_W:0] d;
    d = {v, 1'b0};
    return (d < {1'b0, cap}) ? d[CFG_W-1:0] : cap;
  endfunction

endpackage

// File: rtl/fabs_cfg_regs.sv
// Configuration register file of the fix acquisition backoff scheduler.
// Depends on fabs_pkg.
module fabs_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fabs_pkg::IDX_W-1:0]   cfg_index,
  input  logic [fabs_pkg::CFG_W-1:0]   cfg_data,
  output fabs_pkg::cfg_t               cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_timeout_s <= fabs_pkg::INITIAL_TIMEOUT_RST;
      cfg.max_timeout_s     <= fabs_pkg::MAX_TIMEOUT_RST;
      cfg.scan_timeout_s    <= fabs_pkg::SCAN_TIMEOUT_RST;
      cfg.stale_limit_s     <= fabs_pkg::STALE_LIMIT_RST;
      cfg.initial_probe_s   <= fabs_pkg::INITIAL_PROBE_RST;
      cfg.max_probe_s       <= fabs_pkg::MAX_PROBE_RST;
      cfg.scan_period_s     <= fabs_pkg::SCAN_PERIOD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fabs_pkg::REG_INITIAL_TIMEOUT: cfg.initial_timeout_s <= cfg_data;
        fabs_pkg::REG_MAX_TIMEOUT:     cfg.max_timeout_s     <= cfg_data;
        fabs_pkg::REG_SCAN_TIMEOUT:    cfg.scan_timeout_s    <= cfg_data;
        fabs_pkg::REG_STALE_LIMIT:     cfg.stale_limit_s     <= cfg_data;
        fabs_pkg::REG_INITIAL_PROBE:   cfg.initial_probe_s   <= cfg_data;
        fabs_pkg::REG_MAX_PROBE:       cfg.max_probe_s       <= cfg_data;
        fabs_pkg::REG_SCAN_PERIOD:     cfg.scan_period_s     <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

// File: rtl/fabs_core.sv
// Scheduler state and the single-pass update for one poll or event.
// Depends on fabs_pkg.
module fabs_core #(
  parameter int TIME_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  fabs_pkg::cfg_t         cfg,
  input  logic                   step,
  input  logic                   op,
  input  logic [TIME_BITS-1:0]   now_ms,
  input  logic [1:0]             event_kind,
  output fabs_pkg::result_t      res
);

  fabs_pkg::fix_status_t status, status_next, st;
  logic [TIME_BITS-1:0] last_fix_ms, last_fix_ms_next;
  logic [TIME_BITS-1:0] next_poll_ms, next_poll_ms_next;
  logic first_acquire, first_acquire_next;
  logic request_due, request_due_next;
  logic [fabs_pkg::CFG_W-1:0] acq_timeout_s, acq_timeout_s_next;
  logic [fabs_pkg::CFG_W-1:0] probe_wait_s, probe_wait_s_next;

  logic [TIME_BITS-1:0] poll_diff, fix_age, stale_ms, scan_ms, probe_ms;
  logic poll_due, stale, reinit;
  logic first_v, due_v;
  logic [fabs_pkg::CFG_W-1:0] acq_v, probe_v;

  localparam int PAD = TIME_BITS - fabs_pkg::MS_BITS;

  assign stale_ms  = {{PAD{1'b0}}, fabs_pkg::to_ms(cfg.stale_limit_s)};
  assign scan_ms   = {{PAD{1'b0}}, fabs_pkg::to_ms(cfg.scan_period_s)};
  assign poll_diff = now_ms - next_poll_ms;
  assign fix_age   = now_ms - last_fix_ms;
  // signed difference strictly above the bound
  assign poll_due  = !poll_diff[TIME_BITS-1] && (poll_diff != '0);
  assign stale     = !fix_age[TIME_BITS-1] && (fix_age > stale_ms);
  // only a previous fix can go stale
  assign reinit    = (status == fabs_pkg::ST_PREVIOUS) && stale;

  // stale fix restarts the backoff before the rest of the poll runs
  assign first_v = reinit ? 1'b1 : first_acquire;
  assign due_v   = reinit ? 1'b1 : request_due;
  assign acq_v   = reinit ? cfg.initial_timeout_s : acq_timeout_s;
  assign probe_v = reinit ? cfg.initial_probe_s : probe_wait_s;
  assign probe_ms = {{PAD{1'b0}}, fabs_pkg::to_ms(probe_v)};

  always_comb begin
    status_next        = status;
    last_fix_ms_next   = last_fix_ms;
    next_poll_ms_next  = next_poll_ms;
    first_acquire_next = first_acquire;
    request_due_next   = request_due;
    acq_timeout_s_next = acq_timeout_s;
    probe_wait_s_next  = probe_wait_s;
    st                 = status;
    res                = '0;

    if (op == fabs_pkg::OP_EVENT) begin
      if (event_kind == fabs_pkg::EV_FIX) begin
        last_fix_ms_next = now_ms;
        status_next      = fabs_pkg::ST_CURRENT;
        res.fix_notify   = 1'b1;
      end else if (status == fabs_pkg::ST_CURRENT) begin
        status_next = fabs_pkg::ST_PREVIOUS;
      end else if (status == fabs_pkg::ST_PENDING && event_kind == fabs_pkg::EV_TIMEOUT) begin
        status_next = fabs_pkg::ST_TIMEOUT;
      end
    end else if (poll_due) begin
      if (reinit) begin
        status_next        = fabs_pkg::ST_NONE;
        st                 = fabs_pkg::ST_NONE;
        probe_wait_s_next  = cfg.initial_probe_s;
        acq_timeout_s_next = cfg.initial_timeout_s;
        first_acquire_next = 1'b1;
        request_due_next   = 1'b1;
      end
      if (status == fabs_pkg::ST_PREVIOUS && !stale) begin
        next_poll_ms_next = now_ms + scan_ms;
      end else if (first_v) begin
        if (st == fabs_pkg::ST_NONE || st == fabs_pkg::ST_TIMEOUT) begin
          if (due_v) begin
            res.request_start     = 1'b1;
            res.request_timeout_s = acq_v;
            status_next           = fabs_pkg::ST_PENDING;
            acq_timeout_s_next    = fabs_pkg::double_capped(acq_v, cfg.max_timeout_s);
            next_poll_ms_next     = now_ms;
            request_due_next      = 1'b0;
          end else if (st == fabs_pkg::ST_TIMEOUT) begin
            next_poll_ms_next = next_poll_ms + probe_ms;
            probe_wait_s_next = fabs_pkg::double_capped(probe_v, cfg.max_probe_s);
            request_due_next  = 1'b1;
          end
        end
        if (st == fabs_pkg::ST_CURRENT) begin
          first_acquire_next     = 1'b0;
          res.request_start      = 1'b1;
          res.request_period_s   = cfg.scan_period_s;
          res.request_timeout_s  = cfg.scan_timeout_s;
          res.request_visibility = 1'b1;
          next_poll_ms_next      = now_ms + scan_ms;
        end
      end
    end
    res.fix_status = status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status        <= fabs_pkg::ST_NONE;
      last_fix_ms   <= '0;
      next_poll_ms  <= '0;
      first_acquire <= 1'b1;
      request_due   <= 1'b1;
      acq_timeout_s <= fabs_pkg::INITIAL_TIMEOUT_RST;
      probe_wait_s  <= fabs_pkg::INITIAL_PROBE_RST;
    end else if (step) begin
      status        <= status_next;
      last_fix_ms   <= last_fix_ms_next;
      next_poll_ms  <= next_poll_ms_next;
      first_acquire <= first_acquire_next;
      request_due   <= request_due_next;
      acq_timeout_s <= acq_timeout_s_next;
      probe_wait_s  <= probe_wait_s_next;
    end
  end

endmodule

// File: rtl/fix_acquisition_backoff_scheduler.sv
// Top level of the fix acquisition backoff scheduler: input and result registers.
// Depends on fabs_pkg, fabs_cfg_regs and fabs_core.
//
// Usage:
//   Slave stream (s_*) takes one request per transfer: a poll (s_tuser = 0)
//   carrying the current millisecond time, or a receiver event (s_tuser = 1)
//   carrying its time and event kind. Every request yields exactly one result
//   on the master stream (m_*): whether an acquisition request is issued, its
//   period, timeout and visibility flag, the fix status and a notify flag.
// The config channel writes the seven second-valued registers by index and is
//   always ready; the user writes it only with no request in flight (unenforced).
// Path: a request accepted on s_* is registered in the input register, then
//   processed into the core state and the result register once m_* is free.
// Throughput: one request per cycle while m_tready is high; the whole update is a single pass from
//   the input register into the result register, set by the 48-bit time
//   compare and add through the state update.
// Reset (rst, synchronous): registers return to their defaults, fix status to
//   none, both backoff values to their initial values, pipeline empties.
// Stall: when m_tready is low the result holds, one more request may wait in
//   the input register, then s_tready drops.
module fix_acquisition_backoff_scheduler #(
  parameter int TIME_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [TIME_BITS-1:0] now_ms, [TIME_BITS+1:TIME_BITS] event_kind, rest zero
  input  logic [((TIME_BITS+9)/8)*8-1:0]    s_tdata,
  // [0] operation
  input  logic [0:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] request_start, [16:1] request_period_s, [32:17] request_timeout_s,
  // [33] request_visibility, [36:34] fix_status, [37] fix_notify, rest zero
  output logic [fabs_pkg::RES_W-1:0]        m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fabs_pkg::IDX_W-1:0]        cfg_index,
  input  logic [fabs_pkg::CFG_W-1:0]        cfg_data
);

  fabs_pkg::cfg_t    cfg;
  fabs_pkg::result_t res;

  logic                 in_valid;
  logic                 in_op;
  logic [TIME_BITS-1:0] in_now;
  logic [1:0]           in_kind;
  logic                 advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  fabs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fabs_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (advance),
    .op         (in_op),
    .now_ms     (in_now),
    .event_kind (in_kind),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_op   <= s_tuser[0];
      in_now  <= s_tdata[TIME_BITS-1:0];
      in_kind <= s_tdata[TIME_BITS+1:TIME_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      m_tdata <= {2'b00, res.fix_notify, res.fix_status, res.request_visibility,
                  res.request_timeout_s, res.request_period_s, res.request_start};
    end
  end

endmodule
